// File: design/rth_pkg.sv
package rth_pkg;

	localparam int CHANNEL_BITS_DEF = 8;

	localparam int HUE_W          = 13;
	localparam int HUE_Q_W        = 10;
	localparam int SECTOR_W       = 3;
	localparam int HUE_NUM_SCALE  = 1920;
	localparam int SECTOR_SPAN    = 960;
	localparam int HUE_FULL       = 5760;

	// hue sectors in units of 60 degrees, d always in [0, C]
	localparam logic [SECTOR_W-1:0] SEC_RED_UP   = 3'd0;
	localparam logic [SECTOR_W-1:0] SEC_GREEN_DN = 3'd1;
	localparam logic [SECTOR_W-1:0] SEC_GREEN_UP = 3'd2;
	localparam logic [SECTOR_W-1:0] SEC_BLUE_DN  = 3'd3;
	localparam logic [SECTOR_W-1:0] SEC_BLUE_UP  = 3'd4;
	localparam logic [SECTOR_W-1:0] SEC_RED_DN   = 3'd5;

	function automatic logic [HUE_W-1:0] sector_base(input logic [SECTOR_W-1:0] sec);
		sector_base = HUE_W'(sec) * HUE_W'(SECTOR_SPAN);
	endfunction

endpackage

// File: design/rgb_to_hsv_unit.sv
// RGB to HSV pixel converter.
// Input stream s_*: one pixel per transfer, tdata holds red, green, blue,
// CHANNEL_BITS each, red in the lowest bits. Output stream m_*: one result
// per pixel, tdata holds hue (13 bits, 1/16 degree), saturation and
// brightness (CHANNEL_BITS each), hue in the lowest bits.
// Throughput: one pixel per cycle, sustained while the receiver holds m_tready high.
// Pipeline: max(10, CHANNEL_BITS) + 3 register stages, in order: min/max
// and sector, dividend setup, one restoring division stage per quotient
// bit (hue and saturation divided side by side), output stage.
// Each stage holds its data while the next one is full, so a stalled
// receiver fills the bubbles first; s_tready drops only once every stage
// from the output back to the input holds a pixel. Nothing is lost or
// repeated across a stall.
// Reset clears all stage valid bits; the pipeline comes up empty and
// s_tready is high.
module rgb_to_hsv_unit #(
	parameter int CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                s_tvalid,
	output logic                                                s_tready,
	// red, green, blue
	input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]                 s_tdata,
	output logic                                                m_tvalid,
	input  logic                                                m_tready,
	// hue, saturation, brightness
	output logic [((rth_pkg::HUE_W+2*CHANNEL_BITS+7)/8)*8-1:0] m_tdata
);

	localparam int CB     = CHANNEL_BITS;
	localparam int OUT_W  = ((rth_pkg::HUE_W + 2*CB + 7) / 8) * 8;
	localparam int QUO_W  = (CB > rth_pkg::HUE_Q_W) ? CB : rth_pkg::HUE_Q_W;
	localparam int HN_W   = CB + 11;
	localparam int SN_W   = 2*CB + 1;
	localparam int DEN_W  = CB + 1;
	localparam int NS     = QUO_W + 3;
	localparam int HW     = rth_pkg::HUE_W;
	localparam int SW     = rth_pkg::SECTOR_W;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] rdy;

	always_comb begin
		rdy[NS-1] = !vld_q[NS-1] || m_tready;
		for (int k = NS - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NS; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_tready = rdy[0];
	assign m_tvalid = vld_q[NS-1];

	// stage 1: max, min, sector and in-sector difference
	logic [CB-1:0] red, green, blue;
	logic [CB-1:0] mx, mn, dd;
	logic [SW-1:0] sec;

	assign red   = s_tdata[CB-1:0];
	assign green = s_tdata[2*CB-1:CB];
	assign blue  = s_tdata[3*CB-1:2*CB];

	always_comb begin
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		if (red >= green && red >= blue) begin
			mx = red;
			if (green >= blue) begin
				sec = rth_pkg::SEC_RED_UP;
				dd  = green - blue;
			end else begin
				sec = rth_pkg::SEC_RED_DN;
				dd  = red - blue;
			end
		end else if (green >= blue) begin
			mx = green;
			if (blue >= red) begin
				sec = rth_pkg::SEC_GREEN_UP;
				dd  = blue - red;
			end else begin
				sec = rth_pkg::SEC_GREEN_DN;
				dd  = green - red;
			end
		end else begin
			mx = blue;
			if (red >= green) begin
				sec = rth_pkg::SEC_BLUE_UP;
				dd  = red - green;
			end else begin
				sec = rth_pkg::SEC_BLUE_DN;
				dd  = blue - green;
			end
		end
	end

	logic [CB-1:0] mx_s1, c_s1, d_s1;
	logic [SW-1:0] sec_s1;

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			mx_s1  <= mx;
			c_s1   <= mx - mn;
			d_s1   <= dd;
			sec_s1 <= sec;
		end
	end

	// stage 2: dividends and divisors
	logic [HN_W-1:0]  hnum_s2;
	logic [DEN_W-1:0] hden_s2;
	logic [SN_W-1:0]  snum_s2;
	logic [DEN_W-1:0] sden_s2;
	logic [CB-1:0]    mx_s2;
	logic [SW-1:0]    sec_s2;
	logic             hz_s2, sz_s2;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			hnum_s2 <= HN_W'(d_s1) * HN_W'(rth_pkg::HUE_NUM_SCALE) + HN_W'(c_s1);
			hden_s2 <= {c_s1, 1'b0};
			snum_s2 <= (SN_W'(c_s1) << (CB + 1)) - (SN_W'(c_s1) << 1) + SN_W'(mx_s1);
			sden_s2 <= {mx_s1, 1'b0};
			mx_s2   <= mx_s1;
			sec_s2  <= sec_s1;
			hz_s2   <= (c_s1 == '0);
			sz_s2   <= (mx_s1 == '0);
		end
	end

	// division stages
	logic [QUO_W-1:0] hquo, squo;

	rth_div_pipe #(
		.NUM_W(HN_W),
		.DEN_W(DEN_W),
		.QUO_W(QUO_W)
	) u_hue_div (
		.clk(clk),
		.en (rdy[QUO_W+1:2]),
		.num(hnum_s2),
		.den(hden_s2),
		.quo(hquo)
	);

	rth_div_pipe #(
		.NUM_W(SN_W),
		.DEN_W(DEN_W),
		.QUO_W(QUO_W)
	) u_sat_div (
		.clk(clk),
		.en (rdy[QUO_W+1:2]),
		.num(snum_s2),
		.den(sden_s2),
		.quo(squo)
	);

	logic [CB-1:0] mx_s3  [QUO_W];
	logic [SW-1:0] sec_s3 [QUO_W];
	logic          hz_s3  [QUO_W];
	logic          sz_s3  [QUO_W];

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			mx_s3[0]  <= mx_s2;
			sec_s3[0] <= sec_s2;
			hz_s3[0]  <= hz_s2;
			sz_s3[0]  <= sz_s2;
		end
		for (int k = 1; k < QUO_W; k++) begin
			if (rdy[k+2]) begin
				mx_s3[k]  <= mx_s3[k-1];
				sec_s3[k] <= sec_s3[k-1];
				hz_s3[k]  <= hz_s3[k-1];
				sz_s3[k]  <= sz_s3[k-1];
			end
		end
	end

	// output stage
	logic [HW:0]   hue_sum;
	logic [HW-1:0] hue_s4;
	logic [CB-1:0] sat_s4, val_s4;

	assign hue_sum = (HW+1)'(rth_pkg::sector_base(sec_s3[QUO_W-1]))
		+ (HW+1)'(hquo[rth_pkg::HUE_Q_W-1:0]);

	always_ff @(posedge clk) begin
		if (rdy[NS-1]) begin
			if (hz_s3[QUO_W-1]) begin
				hue_s4 <= '0;
			end else if (hue_sum >= (HW+1)'(rth_pkg::HUE_FULL)) begin
				hue_s4 <= HW'(hue_sum - (HW+1)'(rth_pkg::HUE_FULL));
			end else begin
				hue_s4 <= hue_sum[HW-1:0];
			end
			sat_s4 <= sz_s3[QUO_W-1] ? '0 : squo[CB-1:0];
			val_s4 <= mx_s3[QUO_W-1];
		end
	end

	assign m_tdata = OUT_W'({val_s4, sat_s4, hue_s4});

`ifndef SYNTHESIS
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (hue_s4 < HW'(rth_pkg::HUE_FULL)))
		else $error("hue out of range");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && val_s4 == '0) |-> (sat_s4 == '0 && hue_s4 == '0))
		else $error("black pixel with nonzero hue or saturation");

	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_q[0])
		else $error("accepted pixel not in first stage");
`endif

endmodule

// File: design/rth_div_pipe.sv
module rth_div_pipe #(
	parameter int NUM_W = 19,
	parameter int DEN_W = 9,
	parameter int QUO_W = 10
) (
	input  logic             clk,
	input  logic [QUO_W-1:0] en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	localparam int RW = DEN_W + QUO_W;

	logic [RW-1:0]    rem_s3 [QUO_W-1];
	logic [DEN_W-1:0] den_s3 [QUO_W-1];
	logic [QUO_W-1:0] quo_s3 [QUO_W];

	genvar j;
	generate
		for (j = 0; j < QUO_W; j++) begin : g_step
			logic [RW-1:0]    rin;
			logic [DEN_W-1:0] din;
			logic [QUO_W-1:0] qin;
			logic [RW-1:0]    shd;
			logic             ge;

			if (j == 0) begin : g_first
				assign rin = RW'(num);
				assign din = den;
				assign qin = '0;
			end else begin : g_next
				assign rin = rem_s3[j-1];
				assign din = den_s3[j-1];
				assign qin = quo_s3[j-1];
			end

			assign shd = RW'(din) << (QUO_W - 1 - j);
			assign ge  = (rin >= shd);

			always_ff @(posedge clk) begin
				if (en[j]) begin
					quo_s3[j] <= {qin[QUO_W-2:0], ge};
				end
			end

			if (j < QUO_W - 1) begin : g_rem
				always_ff @(posedge clk) begin
					if (en[j]) begin
						rem_s3[j] <= ge ? (rin - shd) : rin;
						den_s3[j] <= din;
					end
				end
			end
		end
	endgenerate

	assign quo = quo_s3[QUO_W-1];

endmodule

// File: test/tb_rgb_to_hsv_unit.sv
module tb_rgb_to_hsv_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB         = rth_pkg::CHANNEL_BITS_DEF;
	localparam int HW         = rth_pkg::HUE_W;
	localparam int S_W        = ((3*CB+7)/8)*8;
	localparam int M_W        = ((HW+2*CB+7)/8)*8;
	localparam int LATENCY    = ((10 > CB) ? 10 : CB) + 3;
	localparam int STALL_LIMIT = 2000;
	localparam int N_PHASES   = 4;
	localparam int PHASE_ITEMS = 325;

	typedef struct packed {
		logic [CB-1:0] r;
		logic [CB-1:0] g;
		logic [CB-1:0] b;
		logic [1:0]    phase;
		logic          hold_off;
	} pixel_t;

	typedef struct packed {
		logic [HW-1:0] hue;
		logic [CB-1:0] sat;
		logic [CB-1:0] bright;
	} hsv_t;

	// idle / stall percentages per phase: none, sender, receiver, both
	int send_idle_pct [N_PHASES] = '{0, 56, 0, 30};
	int recv_stall_pct[N_PHASES] = '{0, 0, 56, 30};

	logic           clk      = 1'b0;
	logic           arst_n   = 1'b0;
	logic           s_tvalid = 1'b0;
	logic           s_tready;
	// red, green, blue
	logic [S_W-1:0] s_tdata  = '0;
	logic           m_tvalid;
	logic           m_tready = 1'b0;
	// hue, saturation, brightness
	logic [M_W-1:0] m_tdata;

	pixel_t pixel_q[$];
	hsv_t   hsv_expect_q[$];
	logic   in_fire  = 1'b0;
	logic   out_fire = 1'b0;
	logic [1:0] cur_phase = '0;
	int     err_cnt      = 0;
	int     stall_cycles = 0;

	rgb_to_hsv_unit #(.CHANNEL_BITS(CB)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	function automatic hsv_t predict_hsv(input logic [CB-1:0] r, input logic [CB-1:0] g,
			input logic [CB-1:0] b);
		int unsigned mx, mn, chroma, num, hue_v, full;
		hsv_t res;
		full = (1 << CB) - 1;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		chroma = mx - mn;
		hue_v = 0;
		if (chroma != 0) begin
			if (mx == r) begin
				if (g >= b)
					num = g - b;
				else
					num = 6 * chroma - (b - g);
			end else if (mx == g) begin
				num = 2 * chroma + b - r;
			end else begin
				num = 4 * chroma + r - g;
			end
			num = num * rth_pkg::SECTOR_SPAN;
			hue_v = (2 * num + chroma) / (2 * chroma);
			if (hue_v >= rth_pkg::HUE_FULL)
				hue_v = hue_v - rth_pkg::HUE_FULL;
		end
		res.hue    = hue_v[HW-1:0];
		res.sat    = '0;
		if (mx != 0)
			res.sat = CB'((2 * chroma * full + mx) / (2 * mx));
		res.bright = mx[CB-1:0];
		return res;
	endfunction

	task automatic push_pixel(input int r, input int g, input int b, input int phase,
			input bit hold);
		pixel_t p;
		p.r        = CB'(r);
		p.g        = CB'(g);
		p.b        = CB'(b);
		p.phase    = 2'(phase);
		p.hold_off = hold;
		pixel_q.push_back(p);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// driver
	always @(negedge clk) begin
		pixel_t itm;
		logic   nv;
		if (arst_n) begin
			if (!s_tvalid || in_fire) begin
				nv = 1'b0;
				if (pixel_q.size() > 0) begin
					if (pixel_q[0].hold_off && hsv_expect_q.size() != 0) begin
						nv = 1'b0;
					end else if ($urandom_range(99) < send_idle_pct[pixel_q[0].phase]) begin
						nv = 1'b0;
					end else begin
						itm = pixel_q.pop_front();
						nv = 1'b1;
						s_tdata <= {itm.b, itm.g, itm.r};
						cur_phase <= itm.phase;
					end
				end
				s_tvalid <= nv;
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct[cur_phase]);
		end
	end

	// monitor
	always @(posedge clk) begin
		hsv_t exp_v;
		hsv_t act_v;
		in_fire  = s_tvalid && s_tready;
		out_fire = m_tvalid && m_tready;
		if (in_fire)
			hsv_expect_q.push_back(predict_hsv(s_tdata[CB-1:0], s_tdata[2*CB-1:CB],
				s_tdata[3*CB-1:2*CB]));
		if (out_fire) begin
			act_v.hue    = m_tdata[HW-1:0];
			act_v.sat    = m_tdata[HW+CB-1:HW];
			act_v.bright = m_tdata[HW+2*CB-1:HW+CB];
			if (hsv_expect_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected result hue=%0d sat=%0d bright=%0d", $time,
					act_v.hue, act_v.sat, act_v.bright);
			end else begin
				exp_v = hsv_expect_q.pop_front();
				if (act_v.hue !== exp_v.hue || act_v.sat !== exp_v.sat
						|| act_v.bright !== exp_v.bright) begin
					err_cnt++;
					$display({"%0t: mismatch exp hue=%0d sat=%0d bright=%0d,",
						" got hue=%0d sat=%0d bright=%0d"},
						$time, exp_v.hue, exp_v.sat, exp_v.bright,
						act_v.hue, act_v.sat, act_v.bright);
				end
			end
		end
		if (in_fire || out_fire)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
		$display("tb_rgb_to_hsv_unit: done, errors");
		$finish;
	end

	initial begin
		int v, lo, base;
		// directed: extremes, ties, grey, black, red-sector wrap
		push_pixel(0, 0, 0, 0, 0);
		push_pixel(255, 255, 255, 0, 0);
		push_pixel(128, 128, 128, 0, 0);
		push_pixel(255, 0, 0, 0, 0);
		push_pixel(0, 255, 0, 0, 0);
		push_pixel(0, 0, 255, 0, 0);
		push_pixel(255, 255, 0, 0, 0);
		push_pixel(0, 255, 255, 0, 0);
		push_pixel(255, 0, 255, 0, 0);
		push_pixel(255, 0, 1, 0, 0);
		push_pixel(255, 0, 128, 0, 0);
		push_pixel(255, 0, 254, 0, 0);
		push_pixel(1, 0, 0, 0, 0);
		push_pixel(0, 1, 0, 0, 0);
		push_pixel(0, 0, 1, 0, 0);
		push_pixel(1, 1, 0, 0, 0);
		push_pixel(255, 254, 254, 0, 0);
		push_pixel(254, 255, 255, 0, 0);
		push_pixel(254, 254, 255, 0, 0);
		push_pixel(10, 20, 30, 0, 0);
		push_pixel(200, 100, 50, 0, 0);
		push_pixel(17, 255, 3, 0, 0);
		push_pixel(3, 4, 5, 0, 0);
		push_pixel(85, 170, 255, 0, 0);
		for (int ph = 0; ph < N_PHASES; ph++) begin
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				case ($urandom_range(9))
					0: begin
						v = $urandom_range(255);
						push_pixel(v, v, v, ph, i == 0);
					end
					1: begin
						v  = $urandom_range(255);
						lo = $urandom_range(v);
						case ($urandom_range(2))
							0: push_pixel(v, v, lo, ph, i == 0);
							1: push_pixel(v, lo, v, ph, i == 0);
							default: push_pixel(lo, v, v, ph, i == 0);
						endcase
					end
					2: begin
						base = $urandom_range(250);
						push_pixel(base + $urandom_range(5), base + $urandom_range(5),
							base + $urandom_range(5), ph, i == 0);
					end
					default:
						push_pixel($urandom_range(255), $urandom_range(255),
							$urandom_range(255), ph, i == 0);
				endcase
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pixel_q.size() != 0 || s_tvalid || hsv_expect_q.size() != 0)
			@(posedge clk);
		repeat (4 * LATENCY) @(posedge clk);

		if (err_cnt == 0)
			$display("tb_rgb_to_hsv_unit: done, clean");
		else
			$display("tb_rgb_to_hsv_unit: done, errors");
		$finish;
	end

endmodule
